// ===== design/tcw_pkg.sv =====
// Package for the text console writer: geometry constants, codes and item types.
// Used by tcw_front, tcw_back and the top level; depends on nothing.
package tcw_pkg;
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int TAB_STOP    = 8;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int COL_W       = 7;
    localparam int ROW_W       = 6;

    localparam logic [1:0] FUNC_PRINT = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_CLEAR = 2'd3;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_BACK    = 8'd8;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_NUL     = 8'd0;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] char_code;
        logic [6:0] pos_col;
        logic [5:0] pos_row;
    } t_in_item;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] read_data;
        logic       bad_position;
    } t_out_item;

    // Classified command passed from the front part to the back part.
    typedef enum logic [2:0] {
        OP_CHAR, OP_NEWLINE, OP_BACK, OP_TAB, OP_WRITE, OP_READ, OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [7:0]         data;
        logic [ADDR_W-1:0]  addr;
        logic               bad;
    } t_cmd;
endpackage

// ===== design/tcw_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== design/tcw_front.sv =====
// Front part: accepts items, classifies them and computes positioned addresses.
// Depends on tcw_pkg.
module tcw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tcw_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output tcw_pkg::t_cmd     o_cmd
);
    import tcw_pkg::*;

    // Two-entry queue.
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic [12:0] w_idx;
    logic       w_push, w_pop;

    assign o_stall     = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && !o_stall;
    assign w_pop       = i_cmd_take && o_cmd_valid;

    always_comb begin
        w_idx = 13'(i_item.pos_row) * 13'(SCREEN_COLS) + 13'(i_item.pos_col);
        n_cmd.data = i_item.char_code;
        n_cmd.addr = w_idx[ADDR_W-1:0];
        n_cmd.bad  = !(32'(i_item.pos_col) < SCREEN_COLS
                       && 32'(i_item.pos_row) < SCREEN_ROWS);
        unique case (i_item.func)
            FUNC_PRINT: begin
                priority if (i_item.char_code == CH_NEWLINE) n_cmd.op = OP_NEWLINE;
                else if (i_item.char_code == CH_BACK) n_cmd.op = OP_BACK;
                else if (i_item.char_code == CH_TAB) n_cmd.op = OP_TAB;
                else n_cmd.op = OP_CHAR;
                n_cmd.bad = 1'b0;
            end
            FUNC_WRITE: n_cmd.op = OP_WRITE;
            FUNC_READ:  n_cmd.op = OP_READ;
            default: begin
                n_cmd.op  = OP_CLEAR;
                n_cmd.bad = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !w_push) else $error("queue overflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> r_cnt != 2'd0) else $error("pop from empty queue");
endmodule

// ===== design/tcw_back.sv =====
// Back part: sequencer that carries out commands on the cell store and cursor.
// Depends on tcw_pkg and tcw_ram.
module tcw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  tcw_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output tcw_pkg::t_out_item o_item
);
    import tcw_pkg::*;

    localparam int CW = $clog2(SCREEN_COLS);
    localparam int RW = $clog2(SCREEN_ROWS);
    localparam int AW = ADDR_W;
    localparam int LAST_ROW_BASE = (SCREEN_ROWS - 1) * SCREEN_COLS;

    typedef enum logic [8:0] {
        S_CLR    = 9'b000000001, // clearing pass over the store
        S_IDLE   = 9'b000000010,
        S_EXEC   = 9'b000000100,
        S_RDWAIT = 9'b000001000,
        S_TAB    = 9'b000010000,
        S_SCRD   = 9'b000100000, // scroll: read source cell
        S_SCWR   = 9'b001000000, // scroll: write it one row up
        S_FILL   = 9'b010000000, // scroll: fill last row with spaces
        S_OUT    = 9'b100000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [AW-1:0]   r_ptr, n_ptr;
    t_cmd            r_cmd, n_cmd;
    t_out_item       r_out, n_out;
    logic            r_ov, n_ov;
    logic            w_we;
    logic [AW-1:0]   w_addr;
    logic [7:0]      w_wdata, w_rdata;
    logic [AW-1:0]   w_cur;
    logic            w_busy_done;

    tcw_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    assign w_cur = AW'(32'(r_row) * SCREEN_COLS + 32'(r_col));
    assign o_cmd_take = (r_state == S_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign w_busy_done = 1'b0;

    always_comb begin
        n_state   = r_state;
        n_col     = r_col;
        n_row     = r_row;
        n_ptr     = r_ptr;
        n_cmd     = r_cmd;
        n_out     = r_out;
        n_ov      = r_ov && i_stall;
        w_we      = 1'b0;
        w_addr    = w_cur;
        w_wdata   = CH_NUL;
        unique case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_addr  = r_ptr;
                w_wdata = CH_NUL;
                n_ptr   = r_ptr + AW'(1);
                if (32'(r_ptr) == CELL_COUNT - 1) begin
                    n_state = (r_cmd.op == OP_CLEAR) ? S_OUT : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid && !r_ov) begin
                    n_cmd   = i_cmd;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
                unique case (r_cmd.op)
                    OP_CHAR: begin
                        w_we    = 1'b1;
                        w_wdata = r_cmd.data;
                        if (32'(r_col) == SCREEN_COLS - 1) begin
                            n_col = '0;
                            if (32'(r_row) == SCREEN_ROWS - 1) begin
                                n_ptr = '0;
                                n_state = S_SCRD;
                            end else begin
                                n_row = r_row + RW'(1);
                            end
                        end else begin
                            n_col = r_col + CW'(1);
                        end
                    end
                    OP_NEWLINE: begin
                        n_col = '0;
                        if (32'(r_row) == SCREEN_ROWS - 1) begin
                            n_ptr = '0;
                            n_state = S_SCRD;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end
                    OP_BACK: begin
                        w_we = 1'b1;
                        w_wdata = CH_NUL;
                        if (r_col != '0) begin
                            n_col = r_col - CW'(1);
                            w_addr = w_cur - AW'(1);
                        end else if (r_row != '0) begin
                            n_col = CW'(SCREEN_COLS - 1);
                            n_row = r_row - RW'(1);
                            w_addr = w_cur - AW'(1);
                        end
                    end
                    OP_TAB: begin
                        n_state = S_TAB;
                    end
                    OP_WRITE: begin
                        w_we = !r_cmd.bad;
                        w_addr = r_cmd.addr;
                        w_wdata = r_cmd.data;
                    end
                    OP_READ: begin
                        w_addr = r_cmd.addr;
                        n_state = S_RDWAIT;
                    end
                    default: begin
                        n_col = '0;
                        n_row = '0;
                        n_ptr = '0;
                        n_state = S_CLR;
                    end
                endcase
            end
            S_RDWAIT: begin
                // Keep the read address so the registered data still holds the cell.
                w_addr = r_cmd.addr;
                n_state = S_OUT;
            end
            S_TAB: begin
                w_we = 1'b1;
                w_wdata = CH_SPACE;
                n_state = (32'(r_col + CW'(1)) % TAB_STOP == 0) ? S_OUT : S_TAB;
                if (32'(r_col) == SCREEN_COLS - 1) begin
                    n_col = '0;
                    n_state = S_OUT;
                    if (32'(r_row) == SCREEN_ROWS - 1) begin
                        n_ptr = '0;
                        n_state = S_SCRD;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            S_SCRD: begin
                w_addr = AW'(32'(r_ptr) + SCREEN_COLS);
                n_state = S_SCWR;
            end
            S_SCWR: begin
                w_we = 1'b1;
                w_addr = r_ptr;
                w_wdata = w_rdata;
                n_ptr = r_ptr + AW'(1);
                n_state = (32'(r_ptr) == LAST_ROW_BASE - 1) ? S_FILL : S_SCRD;
            end
            S_FILL: begin
                w_we = 1'b1;
                w_addr = r_ptr;
                w_wdata = CH_SPACE;
                n_ptr = r_ptr + AW'(1);
                if (32'(r_ptr) == CELL_COUNT - 1) begin
                    // Cursor was on the bottom row and stays there; column 0 is a tab stop.
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_out.cursor_col = 7'(r_col);
                    n_out.cursor_row = 5'(r_row);
                    n_out.read_data = (r_cmd.op == OP_READ && !r_cmd.bad) ? w_rdata : 8'd0;
                    n_out.bad_position = r_cmd.bad;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_col     <= '0;
            r_row     <= '0;
            r_ptr     <= '0;
            r_ov      <= 1'b0;
            r_cmd.op  <= OP_CHAR;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_row     <= n_row;
            r_ptr     <= n_ptr;
            r_ov      <= n_ov;
            r_cmd.op  <= n_cmd.op;
        end
        r_cmd.data <= n_cmd.data;
        r_cmd.addr <= n_cmd.addr;
        r_cmd.bad  <= n_cmd.bad;
        r_out      <= n_out;
    end

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < SCREEN_COLS) else $error("cursor column out of range");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < SCREEN_ROWS) else $error("cursor row out of range");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> r_state == S_IDLE && !w_busy_done)
        else $error("command taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov) else $error("result lost under stall");
endmodule

// ===== design/text_console_writer_core.sv =====
// Top level of the text console writer: front classifier, command queue, back sequencer.
// Depends on tcw_pkg, tcw_front, tcw_back and tcw_ram.
//
//  Channel | Direction | Handshake         | Payload
//  input   | in        | i_valid/o_stall   | i_item (t_in_item)
//  result  | out       | o_valid/i_stall   | o_item (t_out_item)
//
// A plain character, newline or positioned write passes the back sequencer states take
// (S_IDLE), execute (S_EXEC) and output (S_OUT), and no new command is taken until the
// result has left the output register; a positioned read also passes S_RDWAIT, as the
// registered RAM read needs a wait state. A tab writes spaces in S_TAB up to the next tab
// stop. A scroll reads and rewrites each cell of rows 1 to ROWS-1 through the one port,
// then fills the last row with spaces. A clear, and the clearing pass after reset, write
// each of the 2000 cells in turn; no item leaves the queue meanwhile.
// A stalled result holds in the output register while the front queue, two items
// deep, takes input items until it is full.
module text_console_writer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  tcw_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output tcw_pkg::t_out_item o_item
);
    import tcw_pkg::*;

    logic w_cmd_valid, w_cmd_take;
    t_cmd w_cmd;

    tcw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_cmd_valid(w_cmd_valid),
        .i_cmd_take (w_cmd_take),
        .o_cmd      (w_cmd)
    );

    tcw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .o_cmd_take (w_cmd_take),
        .i_cmd      (w_cmd),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );
endmodule
